// ----- design/bc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bc_pkg: shared types and constants for the binomial coefficient unit
// Item structs, controller states, and the command and status groups that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package bc_pkg;

  localparam int N_W      = 7;
  localparam int RES_W    = 64;
  localparam int ACC_W    = 132;
  localparam int DIGIT_W  = 4;
  localparam int DIGITS   = ACC_W / DIGIT_W;
  localparam int CNT_W    = $clog2(DIGITS);
  localparam logic [N_W-1:0] MAX_N = N_W'(127);

  typedef struct packed {
    logic [N_W-1:0] n_total;
    logic [N_W-1:0] r_chosen;
  } bc_in_t;

  typedef struct packed {
    logic [RES_W-1:0] coefficient;
    logic             overflow;
  } bc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } bc_state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic step;
    logic finish;
  } bc_cmd_t;

  typedef struct packed {
    logic steps_done;
    logic div_last;
  } bc_sts_t;

endpackage
`default_nettype wire

// ----- design/binomial_coefficient_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binomial_coefficient_unit: exact C(n, r) with 64-bit saturating result
// Usage:
//   Drive in_data (n_total, r_chosen) and raise start. The item is taken at
//   a clock edge with start high and busy low; busy then stays high until
//   the result has been shown.
//   The result appears on out_data for exactly one cycle with out_valid high.
//   The receiver cannot stall; it must take the result in that cycle.
//   r is reduced to k = min(r, n - r); r > n gives 0, k = 0 gives 1, and a
//   result above 64 bits gives all ones with overflow set.
// Sequence:
//   Each of the k steps is a check, a multiply and a digit-serial divide
//   (the 132-bit running product divided by i+1, four quotient bits per
//   cycle); a last check then finishes the item. busy falls the cycle
//   after out_valid, and no new item is taken before then.
// Reset:
//   rst_n low returns the controller to idle; any item in flight is dropped.
// ----------------------------------------------------------------------------
module binomial_coefficient_unit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire bc_pkg::bc_in_t in_data,
  output logic                out_valid,
  output bc_pkg::bc_out_t     out_data
);
  import bc_pkg::*;

  bc_cmd_t cmd;
  bc_sts_t sts;

  bc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  bc_dpath u_dpath (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ----- design/bc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bc_ctrl: sequencer for the binomial coefficient unit
// Walks each item through its multiply and digit-serial divide steps.
// ----------------------------------------------------------------------------
module bc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire bc_pkg::bc_sts_t sts,
  output bc_pkg::bc_cmd_t      cmd,
  output logic                 busy,
  output logic                 out_valid
);
  import bc_pkg::*;

  bc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = sts.steps_done ? ST_DONE : ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CHECK: begin
        cmd.finish = sts.steps_done;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
      end
      ST_DIV: begin
        cmd.div  = 1'b1;
        cmd.step = sts.div_last;
      end
      ST_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- design/bc_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bc_dpath: exact wide datapath for the binomial coefficient unit
// Running product with a small-factor multiply and a restoring divide that
// retires four quotient bits per cycle.
// ----------------------------------------------------------------------------
module bc_dpath (
  input  wire logic            clk,
  input  wire bc_pkg::bc_in_t  in_data,
  input  wire bc_pkg::bc_cmd_t cmd,
  output bc_pkg::bc_sts_t      sts,
  output bc_pkg::bc_out_t      out_data
);
  import bc_pkg::*;

  logic [N_W-1:0]   n_r, n_nxt;
  logic [N_W-1:0]   k_r, k_nxt;
  logic [N_W-1:0]   i_r, i_nxt;
  logic [N_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  bc_out_t          out_r, out_nxt;

  logic [N_W-1:0]       n_minus_r;
  logic                 r_gt_n;
  logic                 out_of_range;
  logic [N_W-1:0]       factor;
  logic [N_W-1:0]       divisor;
  logic [ACC_W+N_W-1:0] prod;
  logic [N_W-1:0]       rem_w;
  logic [N_W:0]         rem_t;
  logic [ACC_W-1:0]     quo_w;

  assign n_minus_r    = in_data.n_total - in_data.r_chosen;
  assign r_gt_n       = in_data.r_chosen > in_data.n_total;
  assign out_of_range = r_gt_n || (in_data.n_total > MAX_N);
  assign factor       = n_r - i_r;
  assign divisor      = i_r + N_W'(1);
  assign prod         = {{N_W{1'b0}}, acc_r} * {{ACC_W{1'b0}}, factor};

  // four restoring steps per cycle, rem stays below the divisor
  always_comb begin
    rem_w = rem_r;
    quo_w = acc_r;
    rem_t = '0;
    for (int j = 0; j < DIGIT_W; j++) begin
      rem_t = {rem_w, quo_w[ACC_W-1]};
      quo_w = {quo_w[ACC_W-2:0], 1'b0};
      if (rem_t >= {1'b0, divisor}) begin
        rem_t    = rem_t - {1'b0, divisor};
        quo_w[0] = 1'b1;
      end
      rem_w = rem_t[N_W-1:0];
    end
  end

  always_comb begin
    n_nxt    = n_r;
    k_nxt    = k_r;
    i_nxt    = i_r;
    rem_nxt  = rem_r;
    dcnt_nxt = dcnt_r;
    acc_nxt  = acc_r;
    out_nxt  = out_r;
    if (cmd.load) begin
      n_nxt   = in_data.n_total;
      i_nxt   = '0;
      acc_nxt = out_of_range ? '0 : ACC_W'(1);
      if (out_of_range) begin
        k_nxt = '0;
      end else if (in_data.r_chosen > n_minus_r) begin
        k_nxt = n_minus_r;
      end else begin
        k_nxt = in_data.r_chosen;
      end
    end
    if (cmd.mul) begin
      acc_nxt  = prod[ACC_W-1:0];
      rem_nxt  = '0;
      dcnt_nxt = '0;
    end
    if (cmd.div) begin
      acc_nxt  = quo_w;
      rem_nxt  = rem_w;
      dcnt_nxt = dcnt_r + CNT_W'(1);
    end
    if (cmd.step) begin
      i_nxt = i_r + N_W'(1);
    end
    if (cmd.finish) begin
      out_nxt.overflow    = |acc_r[ACC_W-1:RES_W];
      out_nxt.coefficient = out_nxt.overflow ? '1 : acc_r[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    i_r    <= i_nxt;
    rem_r  <= rem_nxt;
    dcnt_r <= dcnt_nxt;
    acc_r  <= acc_nxt;
    out_r  <= out_nxt;
  end

  assign sts.steps_done = (i_r == k_r);
  assign sts.div_last   = (dcnt_r == CNT_W'(DIGITS - 1));
  assign out_data       = out_r;

endmodule
`default_nettype wire

// ----- design/bc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bc_checker: port-level checks for the binomial coefficient unit
// Bound to the top level; watches the command and result ports.
// ----------------------------------------------------------------------------
module bc_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            start,
  input wire logic            busy,
  input wire logic            out_valid,
  input wire bc_pkg::bc_out_t out_data
);
  import bc_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("item accepted but unit not busy");

  a_result_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while idle");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe not followed by idle");

  a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.overflow) |-> (&out_data.coefficient))
    else $error("overflow without saturated coefficient");

endmodule

bind binomial_coefficient_unit bc_checker u_bc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire
